/* rtl/wss_pkg.sv */
package wss_pkg;

	// field widths
	localparam int COORD_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SPEED_W    = 8;

	// configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MD_W       = 16;
	localparam int MAXS_W     = 7;
	localparam int BASE_W     = 7;
	localparam int DIV_W      = 8;
	localparam int GAIN_W     = 7;

	localparam logic [MD_W-1:0]   MD_RESET   = MD_W'(350);
	localparam logic [MAXS_W-1:0] MAXS_RESET = MAXS_W'(127);
	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(0);
	localparam logic [DIV_W-1:0]  DIV_RESET  = DIV_W'(30);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_DISTANCE  = 2'd0,
		REG_MAX_SPEED     = 2'd1,
		REG_BASE_SPEED    = 2'd2,
		REG_SPEED_DIVISOR = 2'd3
	} cfg_reg_t;

	// arrival test works on 16-bit magnitudes
	localparam int SQ_W = 16;

	// CORDIC vectoring: larger component normalized to [2^58, 2^59)
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W     = 62;
	localparam int NORM_MSB     = 58;
	localparam int NSH_W        = $clog2(NORM_MSB + 1);
	localparam int ANG_ACC_W    = 34;   // 2^-32 turn units, signed

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// bearing rounding to ANGLE_BITS
	localparam int BEAR_SH = 32 - ANGLE_BITS;
	localparam logic signed [ANG_ACC_W-1:0] BEAR_RND = ANG_ACC_W'(1) << (31 - ANGLE_BITS);
	localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

	// heading error to degrees
	localparam int ERR_W  = ANGLE_BITS + 1;
	localparam int PROD_W = ERR_W + 11;
	localparam logic signed [10:0] DEG_SCALE = 11'sd360;
	localparam logic signed [PROD_W-1:0] DEG_BIAS = (PROD_W'(1) << ANGLE_BITS) - PROD_W'(1);
	localparam int DEG_W  = 9;
	localparam int DG_W   = DEG_W + GAIN_W + 1;
	localparam int SUM_W  = DG_W + 1;

	// flags riding beside the CORDIC datapath
	typedef struct packed {
		logic                  arrived;
		logic                  gated;
		logic                  zero;
		logic [ANGLE_BITS-1:0] head;
	} side_t;

endpackage

/* rtl/wss_if.sv */
interface wss_cmd_if;
	import wss_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pose_x;
	logic signed [COORD_BITS-1:0] pose_y;
	logic        [ANGLE_BITS-1:0] heading;
	logic signed [COORD_BITS-1:0] goal_x;
	logic signed [COORD_BITS-1:0] goal_y;
	modport source (output valid, pose_x, pose_y, heading, goal_x, goal_y, input ready);
	modport sink (input valid, pose_x, pose_y, heading, goal_x, goal_y, output ready);
endinterface

interface wss_drive_if;
	import wss_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;
	logic                      arrived;
	logic                      bearing_gated;
	modport source (output valid, left_speed, right_speed, arrived, bearing_gated, input ready);
	modport sink (input valid, left_speed, right_speed, arrived, bearing_gated, output ready);
endinterface

interface wss_cfg_if;
	import wss_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/wss_gain_div.sv */
// gain = round(base / divisor), halves up; restoring divide, one bit a cycle
module wss_gain_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wss_pkg::BASE_W-1:0]  base,
	input  logic [wss_pkg::DIV_W-1:0]   divisor,
	output logic [wss_pkg::GAIN_W-1:0]  gain
);
	import wss_pkg::*;

	localparam int NUM_W = DIV_W + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q, den_q, rem_q, quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             dz_q;
	logic [GAIN_W-1:0] gain_q;

	logic [NUM_W:0]   trial, diff;
	logic             fits;
	logic [NUM_W-1:0] quo_n;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
		quo_n = {quo_q[NUM_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			gain_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				gain_q <= dz_q ? '0 : GAIN_W'(quo_n);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// numerator 2b + d, denominator 2d
			num_q <= (NUM_W'(base) << 1) + NUM_W'(divisor);
			den_q <= NUM_W'(divisor) << 1;
			rem_q <= '0;
			quo_q <= '0;
			dz_q  <= divisor == '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
			num_q <= num_q << 1;
			quo_q <= quo_n;
		end
	end

	assign gain = gain_q;

endmodule

/* rtl/wss_cordic.sv */
// bearing by CORDIC vectoring, one iteration per pipeline stage
module wss_cordic (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [wss_pkg::CORDIC_W-1:0]   x0,
	input  logic signed [wss_pkg::CORDIC_W-1:0]   y0,
	input  wss_pkg::side_t                        side_in,
	output logic                                  out_valid,
	output logic signed [wss_pkg::ANG_ACC_W-1:0]  z,
	output wss_pkg::side_t                        side_out
);
	import wss_pkg::*;

	logic signed [CORDIC_W-1:0]  x_s    [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0]  y_s    [CORDIC_STEPS];
	logic signed [ANG_ACC_W-1:0] z_s    [CORDIC_STEPS];
	side_t                       side_s [CORDIC_STEPS];
	logic                        v_s    [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [ANG_ACC_W-1:0] ATAN_I = ANG_ACC_W'(ATAN_TURNS[i]);

		logic signed [CORDIC_W-1:0]  xi, yi;
		logic signed [ANG_ACC_W-1:0] zi;
		side_t                       si;
		logic                        vi;

		if (i == 0) begin : g_first
			assign xi = x0;
			assign yi = y0;
			assign zi = '0;
			assign si = side_in;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign si = side_s[i-1];
			assign vi = v_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (yi[CORDIC_W-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN_I;
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN_I;
				end
				side_s[i] <= si;
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS-1];
	assign z         = z_s[CORDIC_STEPS-1];
	assign side_out  = side_s[CORDIC_STEPS-1];

endmodule

/* rtl/waypoint_steering_step.sv */
// channel | modport       | word
// --------+---------------+--------------------------------------------------
// cmd     | wss_cmd_if    | pose_x, pose_y, heading, goal_x, goal_y
// drive   | wss_drive_if  | left_speed, right_speed, arrived, bearing_gated
// cfg     | wss_cfg_if    | index, data (min_distance, max_speed, base_speed,
//         |               |   speed_divisor)
//
// One word accepted per cycle while drive is empty or taken; its result reaches
// drive through the stages difference, square/normalize, 30 CORDIC stages, error,
// x360, degree*gain, offset/saturate.
// The whole pipe advances as one while drive is empty or taken; a held
// result freezes every stage, so nothing is lost or repeated.
// arst_n clears valid bits and loads register defaults. cfg is always ready;
// the gain divider restarts after a write and settles well before a word
// accepted after it reaches the gain multiply.
module waypoint_steering_step (
	input  logic        clk,
	input  logic        arst_n,
	wss_cmd_if.sink     cmd,
	wss_drive_if.source drive,
	wss_cfg_if.sink     cfg
);
	import wss_pkg::*;

	// ---------------- configuration ----------------
	logic [MD_W-1:0]   md_q;
	logic [MAXS_W-1:0] maxs_q;
	logic [BASE_W-1:0] base_q;
	logic [DIV_W-1:0]  div_q;
	logic              cfg_wr_q;
	logic [2*SQ_W-1:0] md_sq_q;
	logic [GAIN_W-1:0] gain;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_q     <= MD_RESET;
			maxs_q   <= MAXS_RESET;
			base_q   <= BASE_RESET;
			div_q    <= DIV_RESET;
			cfg_wr_q <= 1'b0;
		end else begin
			cfg_wr_q <= cfg.valid;
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_MIN_DISTANCE:  md_q   <= cfg.data[MD_W-1:0];
					REG_MAX_SPEED:     maxs_q <= cfg.data[MAXS_W-1:0];
					REG_BASE_SPEED:    base_q <= cfg.data[BASE_W-1:0];
					REG_SPEED_DIVISOR: div_q  <= cfg.data[DIV_W-1:0];
				endcase
			end
		end
	end

	// squared radius, recomputed each cycle from a static register
	always_ff @(posedge clk) begin
		md_sq_q <= (2*SQ_W)'(md_q) * (2*SQ_W)'(md_q);
	end

	// gain restarts in the cycle after any write, from the updated registers
	wss_gain_div u_gain (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_wr_q),
		.base    (base_q),
		.divisor (div_q),
		.gain    (gain)
	);

	// ---------------- pipeline control ----------------
	logic en;
	logic v_s1, v_s2, v_s33, v_s34, v_s35, v_s36;

	assign en        = !v_s36 || drive.ready;
	assign cmd.ready = en;

	// ---------------- s1: differences ----------------
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [ANGLE_BITS-1:0]    head_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= {cmd.goal_x[COORD_BITS-1], cmd.goal_x}
				- {cmd.pose_x[COORD_BITS-1], cmd.pose_x};
			dy_s1   <= {cmd.goal_y[COORD_BITS-1], cmd.goal_y}
				- {cmd.pose_y[COORD_BITS-1], cmd.pose_y};
			head_s1 <= cmd.heading;
		end
	end

	// ---------------- s2: squares, normalization ----------------
	logic signed [DIFF_W-1:0] ndx, ndy;
	logic [COORD_BITS-1:0]    ax, ay, mag_a, mag_b, mag_m;
	logic [SQ_W-1:0]          ax16, ay16;
	logic [NSH_W-1:0]         msb, nsh;
	logic signed [CORDIC_W-1:0] x0_n, y0_n;

	always_comb begin
		ndx  = -dx_s1;
		ndy  = -dy_s1;
		ax   = dx_s1[DIFF_W-1] ? ndx[COORD_BITS-1:0] : dx_s1[COORD_BITS-1:0];
		ay   = dy_s1[DIFF_W-1] ? ndy[COORD_BITS-1:0] : dy_s1[COORD_BITS-1:0];
		ax16 = SQ_W'(ax);
		ay16 = SQ_W'(ay);
		// first quadrant only matters here, so the raw low bits are the magnitudes
		mag_a = dx_s1[COORD_BITS-1:0];
		mag_b = dy_s1[COORD_BITS-1:0];
		mag_m = (mag_a > mag_b) ? mag_a : mag_b;
		msb   = '0;
		for (int k = 0; k < COORD_BITS; k++) begin
			if (mag_m[k]) msb = NSH_W'(k);
		end
		nsh  = NSH_W'(NORM_MSB) - msb;
		x0_n = $signed(CORDIC_W'(mag_b) << nsh);
		y0_n = $signed(CORDIC_W'(mag_a) << nsh);
	end

	logic [2*SQ_W-1:0]         sqx_s2, sqy_s2;
	logic                      far_s2, gated_s2, zero_s2;
	logic signed [CORDIC_W-1:0] x0_s2, y0_s2;
	logic [ANGLE_BITS-1:0]     head_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2   <= (2*SQ_W)'(ax16) * (2*SQ_W)'(ax16);
			sqy_s2   <= (2*SQ_W)'(ay16) * (2*SQ_W)'(ay16);
			far_s2   <= ((ax >> SQ_W) != '0) || ((ay >> SQ_W) != '0);
			gated_s2 <= dx_s1[DIFF_W-1] || dy_s1[DIFF_W-1];
			zero_s2  <= (dx_s1 == '0) && (dy_s1 == '0);
			x0_s2    <= x0_n;
			y0_s2    <= y0_n;
			head_s2  <= head_s1;
		end
	end

	// ---------------- s3..s32: arrival compare + CORDIC ----------------
	side_t side_n;
	logic  cv;
	logic signed [ANG_ACC_W-1:0] cz;
	side_t cside;

	always_comb begin
		side_n.arrived = !far_s2 &&
			(({1'b0, sqx_s2} + {1'b0, sqy_s2}) < {1'b0, md_sq_q});
		side_n.gated   = gated_s2;
		side_n.zero    = zero_s2;
		side_n.head    = head_s2;
	end

	wss_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.x0        (x0_s2),
		.y0        (y0_s2),
		.side_in   (side_n),
		.out_valid (cv),
		.z         (cz),
		.side_out  (cside)
	);

	// ---------------- s33: bearing and wrapped heading error ----------------
	logic signed [ANG_ACC_W-1:0] zc, zr;
	logic [ANG_ACC_W-1:0]        zsh;
	logic [ANGLE_BITS-1:0]       bear, e_n;

	always_comb begin
		zc   = cside.zero ? '0 : cz;     // zero vector reads as bearing 0
		zr   = zc + BEAR_RND;
		zsh  = zr >>> BEAR_SH;
		bear = zsh[ANGLE_BITS-1:0];
		e_n  = cside.head - bear;
	end

	logic signed [ERR_W-1:0] err_s33;
	side_t                   side_s33;

	always_ff @(posedge clk) begin
		if (en) begin
			// exact half turn stays positive
			err_s33  <= $signed({e_n > HALF_TURN, e_n});
			side_s33 <= cside;
		end
	end

	// ---------------- s34: error x 360 ----------------
	logic signed [PROD_W-1:0] prod_s34;
	side_t                    side_s34;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s34 <= PROD_W'(err_s33) * PROD_W'(DEG_SCALE);
			side_s34 <= side_s33;
		end
	end

	// ---------------- s35: degrees (toward zero) x gain ----------------
	logic signed [PROD_W-1:0] pb, pb_sh;
	logic signed [DEG_W-1:0]  deg;

	always_comb begin
		pb    = prod_s34 + (prod_s34[PROD_W-1] ? DEG_BIAS : '0);
		pb_sh = pb >>> ANGLE_BITS;
		deg   = pb_sh[DEG_W-1:0];
	end

	logic signed [DG_W-1:0] dg_s35;
	side_t                  side_s35;

	always_ff @(posedge clk) begin
		if (en) begin
			dg_s35   <= DG_W'(deg) * DG_W'($signed({1'b0, gain}));
			side_s35 <= side_s34;
		end
	end

	// ---------------- s36: offset, wheel sums, saturation ----------------
	function automatic logic signed [SPEED_W-1:0] sat_speed(
		input logic signed [SUM_W-1:0] v,
		input logic [MAXS_W-1:0]       lim
	);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		logic signed [SUM_W-1:0] r;
		hi = $signed(SUM_W'(lim));
		lo = -hi;
		if (v > hi) r = hi;
		else if (v < lo) r = lo;
		else r = v;
		return r[SPEED_W-1:0];
	endfunction

	logic signed [DG_W-1:0]  pd, pd_half, off;
	logic signed [SUM_W-1:0] bs, lsum, rsum;

	always_comb begin
		// halve toward zero; shift kept apart so it stays arithmetic
		pd      = dg_s35 + DG_W'(dg_s35[DG_W-1]);
		pd_half = pd >>> 1;
		off     = side_s35.gated ? '0 : pd_half;
		bs      = $signed(SUM_W'(base_q));
		lsum    = bs - SUM_W'(off);
		rsum    = bs + SUM_W'(off);
	end

	logic signed [SPEED_W-1:0] left_s36, right_s36;
	logic                      arrived_s36, gated_s36;

	always_ff @(posedge clk) begin
		if (en) begin
			left_s36    <= side_s35.arrived ? '0 : sat_speed(lsum, maxs_q);
			right_s36   <= side_s35.arrived ? '0 : sat_speed(rsum, maxs_q);
			arrived_s36 <= side_s35.arrived;
			gated_s36   <= side_s35.gated && !side_s35.arrived;
		end
	end

	// valid bits ride along the same enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s33 <= 1'b0;
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
			v_s36 <= 1'b0;
		end else if (en) begin
			v_s1  <= cmd.valid;
			v_s2  <= v_s1;
			v_s33 <= cv;
			v_s34 <= v_s33;
			v_s35 <= v_s34;
			v_s36 <= v_s35;
		end
	end

	assign drive.valid         = v_s36;
	assign drive.left_speed    = left_s36;
	assign drive.right_speed   = right_s36;
	assign drive.arrived       = arrived_s36;
	assign drive.bearing_gated = gated_s36;

	// ---------------- checks ----------------
	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && drive.arrived |->
			drive.left_speed == '0 && drive.right_speed == '0 && !drive.bearing_gated)
		else $error("arrived word carries nonzero drive");

	a_gated_even: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && drive.bearing_gated |-> drive.left_speed == drive.right_speed)
		else $error("gated word has a wheel offset");

	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |->
			drive.left_speed != {1'b1, {(SPEED_W-1){1'b0}}} &&
			drive.right_speed != {1'b1, {(SPEED_W-1){1'b0}}})
		else $error("wheel speed escaped saturation");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> drive.valid && !drive.ready)
		else $error("input stalled with output free");

endmodule

/* tb/wss_steer_checker.sv */
module wss_steer_checker (
	input  logic  clk,
	input  logic  arst_n,
	wss_cmd_if    cmd,
	wss_drive_if  drive,
	wss_cfg_if    cfg,
	output int    fails,
	output int    open_words
);
	timeunit 1ns;
	timeprecision 1ps;
	import wss_pkg::*;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left_spd;
		logic signed [SPEED_W-1:0] right_spd;
		logic                      arrived;
		logic                      gated;
	} drive_word_t;

	// shadow copy of the steering registers
	logic [MD_W-1:0]   min_dist;
	logic [MAXS_W-1:0] max_spd;
	logic [BASE_W-1:0] base_spd;
	logic [DIV_W-1:0]  spd_div;

	drive_word_t pending_drive_q[$];

	initial fails = 0;

	task automatic flag_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		fails++;
	endtask

	// atan2(a, b) in 2^-32 turn, CORDIC vectoring, a and b non-negative
	function automatic longint bearing_turns(longint unsigned a, longint unsigned b);
		longint x, y, z, xs, ys;
		int i;
		if (a == 0 && b == 0)
			return 0;
		while (a < (64'd1 << 58) && b < (64'd1 << 58)) begin
			a = a << 1;
			b = b << 1;
		end
		x = longint'(b);
		y = longint'(a);
		z = 0;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ATAN_TURNS[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ATAN_TURNS[i]);
			end
		end
		return z;
	endfunction

	function automatic longint clamp(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic drive_word_t steer(
		logic signed [COORD_BITS-1:0] px,
		logic signed [COORD_BITS-1:0] py,
		logic        [ANGLE_BITS-1:0] hd,
		logic signed [COORD_BITS-1:0] gx,
		logic signed [COORD_BITS-1:0] gy
	);
		longint dx, dy, ax, ay, z, rnd, err, deg, gain, offset, l, r;
		logic [ANGLE_BITS-1:0] bear, e;
		drive_word_t w;
		w = '0;
		offset = 0;
		dx = longint'(gx) - longint'(px);
		dy = longint'(gy) - longint'(py);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if (ax < 65536 && ay < 65536)
			w.arrived = (ax * ax + ay * ay) < longint'(min_dist) * longint'(min_dist);
		if (!w.arrived) begin
			if (dx < 0 || dy < 0) begin
				w.gated = 1'b1;
			end else begin
				z = bearing_turns(dx, dy);
				rnd = z + (longint'(1) << (31 - ANGLE_BITS));
				bear = rnd[32-ANGLE_BITS +: ANGLE_BITS];
				e = hd - bear;
				err = longint'(e);
				if (e > HALF_TURN)
					err = err - (longint'(1) << ANGLE_BITS);
				deg = (err * 360) / (longint'(1) << ANGLE_BITS);
				gain = (spd_div == 0) ? 0 :
					(2 * longint'(base_spd) + longint'(spd_div)) / (2 * longint'(spd_div));
				offset = (deg * gain) / 2;
			end
			l = clamp(longint'(base_spd) - offset, longint'(max_spd));
			r = clamp(longint'(base_spd) + offset, longint'(max_spd));
			w.left_spd  = l[SPEED_W-1:0];
			w.right_spd = r[SPEED_W-1:0];
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_word_t want;
		if (!arst_n) begin
			min_dist = MD_RESET;
			max_spd  = MAXS_RESET;
			base_spd = BASE_RESET;
			spd_div  = DIV_RESET;
			pending_drive_q.delete();
			open_words <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_MIN_DISTANCE:  min_dist = cfg.data[MD_W-1:0];
					REG_MAX_SPEED:     max_spd  = cfg.data[MAXS_W-1:0];
					REG_BASE_SPEED:    base_spd = cfg.data[BASE_W-1:0];
					REG_SPEED_DIVISOR: spd_div  = cfg.data[DIV_W-1:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				pending_drive_q.push_back(steer(cmd.pose_x, cmd.pose_y, cmd.heading,
					cmd.goal_x, cmd.goal_y));
			if (drive.valid && drive.ready) begin
				if (pending_drive_q.size() == 0) begin
					flag_mismatch("drive word with no command outstanding");
				end else begin
					want = pending_drive_q.pop_front();
					if (drive.left_speed !== want.left_spd)
						flag_mismatch($sformatf("left_speed got %0d want %0d",
							drive.left_speed, want.left_spd));
					if (drive.right_speed !== want.right_spd)
						flag_mismatch($sformatf("right_speed got %0d want %0d",
							drive.right_speed, want.right_spd));
					if (drive.arrived !== want.arrived)
						flag_mismatch($sformatf("arrived got %b want %b",
							drive.arrived, want.arrived));
					if (drive.bearing_gated !== want.gated)
						flag_mismatch($sformatf("bearing_gated got %b want %b",
							drive.bearing_gated, want.gated));
				end
			end
			open_words <= pending_drive_q.size();
		end
	end

endmodule

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wss_pkg::*;

	localparam int RUN_LIMIT   = 200000;  // cycles
	localparam int HOLD_CYCLES = 400;     // long drive stall, far deeper than the pipe
	localparam int DRAIN       = 60;      // pipe is 36 deep; watch for stray words

	logic clk;
	logic arst_n;

	wss_cmd_if   cmd();
	wss_drive_if drive();
	wss_cfg_if   cfg();

	int   fails;
	int   open_words;
	int   cycles = 0;
	int   send_idle;    // percent of cycles the command side sits idle
	int   recv_stall;   // percent of cycles the drive side refuses a word
	logic hold;
	bit   hold_go;

	waypoint_steering_step dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.drive  (drive),
		.cfg    (cfg)
	);

	wss_steer_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.drive      (drive),
		.cfg        (cfg),
		.fails      (fails),
		.open_words (open_words)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// drive side: random stalls, plus the long hold-off below
	initial begin
		drive.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			drive.ready <= !hold && ($urandom_range(99) >= recv_stall);
		end
	end

	// long hold-off, counted on its own so the sender keeps pushing words
	// until the pipe backs up into cmd.ready
	initial begin
		hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	// one command word; valid stays up after acceptance so back-to-back
	// words need no second assignment in the same step
	task automatic send_pose(
		input logic signed [COORD_BITS-1:0] px,
		input logic signed [COORD_BITS-1:0] py,
		input logic        [ANGLE_BITS-1:0] hd,
		input logic signed [COORD_BITS-1:0] gx,
		input logic signed [COORD_BITS-1:0] gy
	);
		while ($urandom_range(99) < send_idle) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid   <= 1'b1;
		cmd.pose_x  <= px;
		cmd.pose_y  <= py;
		cmd.heading <= hd;
		cmd.goal_x  <= gx;
		cmd.goal_y  <= gy;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// random pose/target; most words aimed into the first quadrant or
	// close to the pose so arrival and steering both get exercised
	task automatic rand_pose();
		logic signed [COORD_BITS-1:0] px, py, gx, gy, t;
		logic        [ANGLE_BITS-1:0] hd;
		int kind;
		px = COORD_BITS'($urandom);
		py = COORD_BITS'($urandom);
		gx = COORD_BITS'($urandom);
		gy = COORD_BITS'($urandom);
		hd = ANGLE_BITS'($urandom);
		kind = $urandom_range(3);
		case (kind)
			1: begin
				// goal up and right of pose: steering path
				if (gx < px) begin
					t = gx; gx = px; px = t;
				end
				if (gy < py) begin
					t = gy; gy = py; py = t;
				end
			end
			2: begin
				// near pose, any direction: arrival boundary
				gx = px + ($signed(16'($urandom)) >>> $urandom_range(15));
				gy = py + ($signed(16'($urandom)) >>> $urandom_range(15));
			end
			3: begin
				// near pose, up and right
				gx = px + (16'($urandom) >> $urandom_range(1, 15));
				gy = py + (16'($urandom) >> $urandom_range(1, 15));
			end
			default: ;
		endcase
		send_pose(px, py, hd, gx, gy);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// all four registers; junk in the unused upper data bits
	task automatic load_regs(
		input logic [MD_W-1:0]   md,
		input logic [MAXS_W-1:0] maxs,
		input logic [BASE_W-1:0] base,
		input logic [DIV_W-1:0]  div
	);
		cfg_write(REG_MIN_DISTANCE, md);
		cfg_write(REG_MAX_SPEED, {9'($urandom), maxs});
		cfg_write(REG_BASE_SPEED, {9'($urandom), base});
		cfg_write(REG_SPEED_DIVISOR, {8'($urandom), div});
		cfg.valid <= 1'b0;
	endtask

	// drop valid and wait for every outstanding drive word; the extra edge
	// lets the checker count the last accepted command
	task automatic drain_pipe();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (open_words != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input int idle, input int stall);
		send_idle  = idle;
		recv_stall = stall;
		repeat (n) rand_pose();
		drain_pipe();
	endtask

	task automatic random_regs();
		load_regs(MD_W'($urandom_range(2000)), MAXS_W'($urandom_range(127)),
			BASE_W'($urandom_range(127)), DIV_W'($urandom_range(1, 40)));
	endtask

	initial begin
		arst_n       = 1'b0;
		send_idle    = 0;
		recv_stall   = 0;
		hold_go      = 1'b0;
		cmd.valid   <= 1'b0;
		cmd.pose_x  <= '0;
		cmd.pose_y  <= '0;
		cmd.heading <= '0;
		cmd.goal_x  <= '0;
		cmd.goal_y  <= '0;
		cfg.valid   <= 1'b0;
		cfg.index   <= REG_MIN_DISTANCE;
		cfg.data    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: gain 2, saturation at 100
		load_regs(16'd350, 7'd100, 7'd60, 8'd30);
		send_pose(0, 0, 16'h0000, 0, 0);                  // on target
		send_pose(0, 0, 16'h0000, 349, 0);                // just inside radius
		send_pose(0, 0, 16'h0000, 350, 0);                // on radius: not arrived
		send_pose(0, 0, 16'h0000, 247, 247);              // diagonal, inside
		send_pose(0, 0, 16'h0000, 248, 248);              // diagonal, outside
		send_pose(-32768, -32768, 16'h0000, 32767, 32767); // widest span
		send_pose(32767, 32767, 16'h0000, -32768, -32768); // widest, both negative
		send_pose(0, 0, 16'h0000, -1000, 1000);           // dx < 0: gated
		send_pose(0, 0, 16'h0000, 1000, -1000);           // dy < 0: gated
		send_pose(0, 0, 16'h0000, 0, 1000);               // bearing zero
		send_pose(0, 0, 16'h8000, 0, 1000);               // exact half-turn error
		send_pose(0, 0, 16'h8001, 0, 1000);               // just past half turn
		send_pose(0, 0, 16'hFFFF, 0, 1000);               // heading wrap
		send_pose(0, 0, 16'h4000, 1000, 0);               // quarter turn bearing
		send_pose(0, 0, 16'h7FFF, 1000, 1000);
		send_pose(-32768, 0, 16'h1234, 32767, 0);         // dx 65535
		send_pose(100, -200, 16'h1234, 5000, 3000);
		drain_pipe();

		// zero radius and zero divisor: zero vector still steers, gain 0
		load_regs(16'd0, 7'd127, 7'd127, 8'd0);
		send_pose(0, 0, 16'h0000, 0, 0);
		send_pose(5, 5, 16'h2000, 5, 5);
		send_pose(0, 0, 16'h8000, 100, 100);
		drain_pipe();

		// max speed zero clamps everything
		load_regs(16'd350, 7'd0, 7'd127, 8'd1);
		send_pose(0, 0, 16'h8000, 2000, 3000);
		send_pose(0, 0, 16'h0000, -2000, 3000);
		drain_pipe();

		// random words across register extremes and idling mixes
		load_regs(16'd350, 7'd127, 7'd127, 8'd1);
		run_phase(200, 0, 0);
		load_regs(16'd0, 7'd0, 7'd0, 8'd255);
		run_phase(150, 73, 0);
		load_regs(16'd65535, 7'd127, 7'd64, 8'd0);
		run_phase(150, 0, 73);
		random_regs();
		run_phase(200, 35, 35);

		// back-pressure: drive held off while commands keep coming
		random_regs();
		hold_go = 1'b1;
		run_phase(150, 0, 0);

		random_regs();
		run_phase(150, 0, 0);

		repeat (DRAIN) @(posedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
